### hw/rtl/tlsf_free_block_index_assert.svh
// Assertion macros used by the free block index datapath.
// Each macro expects signals named clk and rst in the using module.
`ifndef TLSF_FREE_BLOCK_INDEX_ASSERT_SVH
`define TLSF_FREE_BLOCK_INDEX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLSF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("free block index assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TLSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("free block index assertion failed");

`endif

### hw/rtl/tlsf_pkg.sv
// Shared types, constants and helper functions of the free block index.
// Used by the request interfaces, the controller, the datapath and the top level.
package tlsf_pkg;

  localparam int NUM_HANDLES = 1024;
  localparam int HANDLE_W    = $clog2(NUM_HANDLES);
  localparam int LINK_W      = HANDLE_W + 1;
  localparam int SIZE_W      = 32;
  localparam int NUM_CLASSES = 32;
  localparam int FL_W        = 5;
  localparam int SC_W        = 5;
  localparam int BUCKET_W    = FL_W + SC_W;
  localparam int NUM_BUCKETS = 1 << BUCKET_W;
  localparam int CFG_W       = 3;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_HANDLES);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_UNLINK = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [CFG_W-1:0] SL_WIDE_MIN = CFG_W'(5);

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR_STEP,
    CMD_CLZ,
    CMD_SHIFT,
    CMD_BAD,
    CMD_UNLINK,
    CMD_INS_RD,
    CMD_INS_WR,
    CMD_INS_LINK,
    CMD_HEAD_B,
    CMD_WALK_FIRST,
    CMD_WALK,
    CMD_FB1,
    CMD_FB2,
    CMD_HEAD_FS,
    CMD_PICK,
    CMD_DET_RD,
    CMD_DET_LOAD,
    CMD_DET_A,
    CMD_DET_B,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       size_zero;
    logic       listed;
    logic       hit;
    logic       found;
    logic       walk_end;
    logic       sm_nz;
    logic       fm_nz;
    logic       clr_last;
  } dp_stat_t;

  // Position of the most significant set bit; zero for a zero word.
  function automatic logic [FL_W-1:0] top_bit(input logic [SIZE_W-1:0] v);
    logic [FL_W-1:0] m;
    m = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) m = FL_W'(i);
    end
    return m;
  endfunction

  // Position of the least significant set bit of a nonzero word.
  function automatic logic [FL_W-1:0] low_bit(input logic [NUM_CLASSES-1:0] v);
    logic [FL_W-1:0] m;
    m = FL_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (v[i]) m = FL_W'(i);
    end
    return m;
  endfunction

endpackage

### hw/rtl/tlsf_req_if.sv
// Request channel of the free block index: operation, handle and size.
// Depends on tlsf_pkg for field widths.
interface tlsf_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic [tlsf_pkg::HANDLE_W-1:0]  block_handle;
  logic [tlsf_pkg::SIZE_W-1:0]    size;

  modport source (output valid, output op, output block_handle, output size, input ready);
  modport sink   (input valid, input op, input block_handle, input size, output ready);
endinterface

### hw/rtl/tlsf_rsp_if.sv
// Response channel of the free block index: status, handle and size.
// Depends on tlsf_pkg for field widths.
interface tlsf_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [tlsf_pkg::HANDLE_W-1:0]  result_handle;
  logic [tlsf_pkg::SIZE_W-1:0]    result_size;

  modport source (output valid, output status, output result_handle, output result_size,
                  input ready);
  modport sink   (input valid, input status, input result_handle, input result_size,
                  output ready);
endinterface

### hw/rtl/tlsf_cfg_if.sv
// Configuration write channel carrying the second level class width register.
// Depends on tlsf_pkg for the register width.
interface tlsf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tlsf_pkg::CFG_W-1:0]   second_level_bits;

  modport source (output valid, output second_level_bits, input ready);
  modport sink   (input valid, input second_level_bits, output ready);
endinterface

### hw/rtl/tlsf_dp.sv
// Datapath of the free block index: bitmaps, link memories and class logic.
// Depends on tlsf_pkg and the assertion macro header; driven by tlsf_ctrl.
`include "tlsf_free_block_index_assert.svh"

module tlsf_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  tlsf_pkg::cmd_t                 cmd,
  input  logic                           cfg_fire,
  input  logic [tlsf_pkg::CFG_W-1:0]     cfg_data,
  input  logic [1:0]                     op_in,
  input  logic [tlsf_pkg::HANDLE_W-1:0]  handle_in,
  input  logic [tlsf_pkg::SIZE_W-1:0]    size_in,
  output tlsf_pkg::dp_stat_t             stat,
  output logic [1:0]                     status,
  output logic [tlsf_pkg::HANDLE_W-1:0]  result_handle,
  output logic [tlsf_pkg::SIZE_W-1:0]    result_size
);

  localparam int HW = tlsf_pkg::HANDLE_W;
  localparam int LW = tlsf_pkg::LINK_W;
  localparam int SW = tlsf_pkg::SIZE_W;
  localparam int NC = tlsf_pkg::NUM_CLASSES;

  // Memories.
  logic [HW-1:0] head_mem   [tlsf_pkg::NUM_BUCKETS];
  logic [SW-1:0] size_mem   [tlsf_pkg::NUM_HANDLES];
  logic [LW-1:0] next_mem   [tlsf_pkg::NUM_HANDLES];
  logic [LW-1:0] prev_mem   [tlsf_pkg::NUM_HANDLES];
  logic          listed_mem [tlsf_pkg::NUM_HANDLES];

  // Bitmaps and control registers.
  logic [NC-1:0] smap [NC];
  logic [NC-1:0] fmap;
  logic          sl5;
  logic [HW-1:0] clr_cnt;

  // Working registers.
  logic [1:0]                   op_r;
  logic [HW-1:0]                h_r;
  logic [SW-1:0]                csize;
  logic [tlsf_pkg::FL_W-1:0]    m_r;
  logic [tlsf_pkg::FL_W-1:0]    fl_r;
  logic [tlsf_pkg::SC_W-1:0]    sc_r;
  logic [tlsf_pkg::FL_W-1:0]    f_r;
  logic [tlsf_pkg::SC_W-1:0]    s_r;
  logic [HW-1:0]                cur_r;
  logic [HW-1:0]                t_r;
  logic [LW-1:0]                p_r;
  logic [LW-1:0]                n_r;
  logic [1:0]                   res_status;
  logic [HW-1:0]                res_handle;
  logic [SW-1:0]                res_size;

  // Registered memory read data.
  logic [HW-1:0] head_q;
  logic [SW-1:0] size_q;
  logic [LW-1:0] next_q;
  logic [LW-1:0] prev_q;
  logic          listed_q;

  // Memory port controls.
  logic                          head_we, head_re, size_we, size_re;
  logic                          next_we, next_re, prev_we, prev_re, listed_we, listed_re;
  logic [tlsf_pkg::BUCKET_W-1:0] head_wa, head_ra;
  logic [HW-1:0]                 head_wd;
  logic [HW-1:0]                 size_wa, size_ra, next_wa, next_ra, prev_wa, prev_ra;
  logic [HW-1:0]                 listed_wa, listed_ra;
  logic [SW-1:0]                 size_wd;
  logic [LW-1:0]                 next_wd, prev_wd;
  logic                          listed_wd;

  // Class and bitmap search logic.
  logic [tlsf_pkg::BUCKET_W-1:0] b_idx, fs_idx;
  logic [NC-1:0]                 smap_fl, sm, fm;
  logic [SW-1:0]                 norm;
  logic                          hit, found;

  assign b_idx   = {fl_r, sc_r};
  assign fs_idx  = {f_r, s_r};
  assign smap_fl = smap[fl_r];
  assign hit     = smap_fl[sc_r];
  assign sm      = smap_fl & (~NC'(1) << sc_r);
  assign fm      = fmap & (~NC'(1) << fl_r);
  assign norm    = csize << (tlsf_pkg::FL_W'(SW - 1) - m_r);
  assign found   = size_q >= csize;

  assign stat.op        = op_r;
  assign stat.size_zero = (csize == '0);
  assign stat.listed    = listed_q;
  assign stat.hit       = hit;
  assign stat.found     = found;
  assign stat.walk_end  = next_q[LW-1];
  assign stat.sm_nz     = (sm != '0);
  assign stat.fm_nz     = (fm != '0);
  assign stat.clr_last  = (clr_cnt == HW'(tlsf_pkg::NUM_HANDLES - 1));

  always_comb begin
    head_we = 1'b0; head_re = 1'b0; head_wa = b_idx; head_ra = b_idx; head_wd = h_r;
    size_we = 1'b0; size_re = 1'b0; size_wa = h_r; size_ra = t_r; size_wd = csize;
    next_we = 1'b0; next_re = 1'b0; next_wa = h_r; next_ra = t_r; next_wd = tlsf_pkg::LINK_NONE;
    prev_we = 1'b0; prev_re = 1'b0; prev_wa = h_r; prev_ra = t_r; prev_wd = tlsf_pkg::LINK_NONE;
    listed_we = 1'b0; listed_re = 1'b0; listed_wa = h_r; listed_ra = handle_in;
    listed_wd = 1'b0;
    case (cmd)
      tlsf_pkg::CMD_LOAD: begin
        listed_re = 1'b1;
      end
      tlsf_pkg::CMD_CLEAR_STEP: begin
        listed_we = 1'b1;
        listed_wa = clr_cnt;
      end
      tlsf_pkg::CMD_INS_RD, tlsf_pkg::CMD_HEAD_B: begin
        head_re = 1'b1;
      end
      tlsf_pkg::CMD_INS_WR: begin
        size_we   = 1'b1;
        prev_we   = 1'b1;
        next_we   = 1'b1;
        next_wd   = hit ? LW'(head_q) : tlsf_pkg::LINK_NONE;
        head_we   = 1'b1;
        listed_we = 1'b1;
        listed_wd = 1'b1;
      end
      tlsf_pkg::CMD_INS_LINK: begin
        prev_we = 1'b1;
        prev_wa = head_q;
        prev_wd = LW'(h_r);
      end
      tlsf_pkg::CMD_WALK_FIRST: begin
        size_re = 1'b1; size_ra = head_q;
        next_re = 1'b1; next_ra = head_q;
      end
      tlsf_pkg::CMD_WALK: begin
        size_re = 1'b1; size_ra = next_q[HW-1:0];
        next_re = 1'b1; next_ra = next_q[HW-1:0];
      end
      tlsf_pkg::CMD_HEAD_FS: begin
        head_re = 1'b1;
        head_ra = fs_idx;
      end
      tlsf_pkg::CMD_DET_RD: begin
        size_re = 1'b1;
        next_re = 1'b1;
        prev_re = 1'b1;
      end
      tlsf_pkg::CMD_DET_A: begin
        if (p_r[LW-1]) begin
          head_we = 1'b1;
          head_wd = n_r[HW-1:0];
        end else begin
          next_we = 1'b1;
          next_wa = p_r[HW-1:0];
          next_wd = n_r;
        end
      end
      tlsf_pkg::CMD_DET_B: begin
        if (!n_r[LW-1]) begin
          prev_we = 1'b1;
          prev_wa = n_r[HW-1:0];
          prev_wd = p_r;
        end
        listed_we = 1'b1;
        listed_wa = t_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    if (size_re) size_q <= size_mem[size_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_q <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk) begin
    if (listed_we) listed_mem[listed_wa] <= listed_wd;
    if (listed_re) listed_q <= listed_mem[listed_ra];
  end

  // Bitmaps, class width and clearing counter.
  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      sl5     <= rst ? 1'b0 : (cfg_data >= tlsf_pkg::SL_WIDE_MIN);
      fmap    <= '0;
      clr_cnt <= '0;
      for (int i = 0; i < NC; i++) begin
        smap[i] <= '0;
      end
    end else begin
      case (cmd)
        tlsf_pkg::CMD_CLEAR_STEP: clr_cnt <= clr_cnt + HW'(1);
        tlsf_pkg::CMD_INS_WR: begin
          smap[fl_r][sc_r] <= 1'b1;
          fmap[fl_r]       <= 1'b1;
        end
        tlsf_pkg::CMD_DET_A: begin
          if (p_r[LW-1] && n_r[LW-1]) smap[fl_r][sc_r] <= 1'b0;
        end
        tlsf_pkg::CMD_DET_B: begin
          if (smap_fl == '0) fmap[fl_r] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    case (cmd)
      tlsf_pkg::CMD_LOAD: begin
        op_r  <= op_in;
        h_r   <= handle_in;
        csize <= size_in;
      end
      tlsf_pkg::CMD_CLZ: m_r <= tlsf_pkg::top_bit(csize);
      tlsf_pkg::CMD_SHIFT: begin
        fl_r <= m_r;
        sc_r <= sl5 ? norm[SW-2:SW-6] : {1'b0, norm[SW-2:SW-5]};
      end
      tlsf_pkg::CMD_BAD: begin
        res_status <= tlsf_pkg::ST_BAD;
        res_handle <= '0;
        res_size   <= '0;
      end
      tlsf_pkg::CMD_UNLINK: t_r <= h_r;
      tlsf_pkg::CMD_INS_WR: begin
        res_status <= tlsf_pkg::ST_DONE;
        res_handle <= '0;
        res_size   <= '0;
      end
      tlsf_pkg::CMD_WALK_FIRST: cur_r <= head_q;
      tlsf_pkg::CMD_WALK: begin
        if (found) t_r <= cur_r;
        else cur_r <= next_q[HW-1:0];
      end
      tlsf_pkg::CMD_FB1: begin
        res_status <= tlsf_pkg::ST_NOFIT;
        res_handle <= '0;
        res_size   <= '0;
        if (sm != '0) begin
          f_r <= fl_r;
          s_r <= tlsf_pkg::low_bit(sm);
        end else begin
          f_r <= tlsf_pkg::low_bit(fm);
        end
      end
      tlsf_pkg::CMD_FB2: s_r <= tlsf_pkg::low_bit(smap[f_r]);
      tlsf_pkg::CMD_PICK: t_r <= head_q;
      tlsf_pkg::CMD_DET_LOAD: begin
        csize <= size_q;
        p_r   <= prev_q;
        n_r   <= next_q;
      end
      tlsf_pkg::CMD_DET_B: begin
        res_status <= tlsf_pkg::ST_DONE;
        res_handle <= (op_r == tlsf_pkg::OP_ALLOC) ? t_r : '0;
        res_size   <= (op_r == tlsf_pkg::OP_ALLOC) ? csize : '0;
      end
      tlsf_pkg::CMD_EMIT: begin
        status        <= res_status;
        result_handle <= res_handle;
        result_size   <= res_size;
      end
      default: begin
      end
    endcase
  end

  // A configuration write empties both bitmaps.
  `TLSF_ASSERT_NEXT(a_cfg_clears, cfg_fire, fmap == '0)
  // An insert leaves its bucket and first class marked non-empty.
  `TLSF_ASSERT_NEXT(a_ins_marks, cmd == tlsf_pkg::CMD_INS_WR, smap[$past(fl_r)][$past(sc_r)])
  // Removing the only block of a bucket clears its bit.
  `TLSF_ASSERT_NEXT(a_det_empties, cmd == tlsf_pkg::CMD_DET_A && p_r[LW-1] && n_r[LW-1],
                    !smap[$past(fl_r)][$past(sc_r)])
  // A set first class bit always has a non-empty second level map behind it.
  `TLSF_ASSERT_SAME(a_fmap_backed, cmd == tlsf_pkg::CMD_FB2, smap[f_r] != '0)

endmodule

### hw/rtl/tlsf_ctrl.sv
// Controller of the free block index: sequences each request through the datapath.
// Depends on tlsf_pkg for the command and status types.
module tlsf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_fire,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  tlsf_pkg::dp_stat_t stat,
  output tlsf_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CLZ, S_SHIFT, S_DISPATCH,
    S_INS_RD, S_INS_WR, S_INS_LINK,
    S_HEAD_B, S_WALK_FIRST, S_WALK,
    S_FB1, S_FB2, S_HEAD_FS, S_PICK,
    S_DET_RD, S_DET_LOAD, S_DET_CLZ, S_DET_SHIFT, S_DET_A, S_DET_B,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   bad;

  assign req_ready = (state == S_IDLE);

  assign bad = (stat.op != tlsf_pkg::OP_INSERT && stat.op != tlsf_pkg::OP_ALLOC &&
                stat.op != tlsf_pkg::OP_UNLINK) ||
               (stat.op != tlsf_pkg::OP_UNLINK && stat.size_zero) ||
               (stat.op == tlsf_pkg::OP_INSERT && stat.listed) ||
               (stat.op == tlsf_pkg::OP_UNLINK && !stat.listed);

  always_comb begin
    state_next = state;
    cmd        = tlsf_pkg::CMD_NONE;
    case (state)
      S_CLEAR: begin
        cmd = tlsf_pkg::CMD_CLEAR_STEP;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd        = tlsf_pkg::CMD_LOAD;
          state_next = S_CLZ;
        end
      end
      S_CLZ: begin
        cmd        = tlsf_pkg::CMD_CLZ;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd        = tlsf_pkg::CMD_SHIFT;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (bad) begin
          cmd        = tlsf_pkg::CMD_BAD;
          state_next = S_DONE;
        end else if (stat.op == tlsf_pkg::OP_INSERT) begin
          state_next = S_INS_RD;
        end else if (stat.op == tlsf_pkg::OP_UNLINK) begin
          cmd        = tlsf_pkg::CMD_UNLINK;
          state_next = S_DET_RD;
        end else begin
          state_next = stat.hit ? S_HEAD_B : S_FB1;
        end
      end
      S_INS_RD: begin
        cmd        = tlsf_pkg::CMD_INS_RD;
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        cmd        = tlsf_pkg::CMD_INS_WR;
        state_next = stat.hit ? S_INS_LINK : S_DONE;
      end
      S_INS_LINK: begin
        cmd        = tlsf_pkg::CMD_INS_LINK;
        state_next = S_DONE;
      end
      S_HEAD_B: begin
        cmd        = tlsf_pkg::CMD_HEAD_B;
        state_next = S_WALK_FIRST;
      end
      S_WALK_FIRST: begin
        cmd        = tlsf_pkg::CMD_WALK_FIRST;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd = tlsf_pkg::CMD_WALK;
        if (stat.found) state_next = S_DET_RD;
        else if (stat.walk_end) state_next = S_FB1;
      end
      S_FB1: begin
        cmd = tlsf_pkg::CMD_FB1;
        if (stat.sm_nz) state_next = S_HEAD_FS;
        else if (stat.fm_nz) state_next = S_FB2;
        else state_next = S_DONE;
      end
      S_FB2: begin
        cmd        = tlsf_pkg::CMD_FB2;
        state_next = S_HEAD_FS;
      end
      S_HEAD_FS: begin
        cmd        = tlsf_pkg::CMD_HEAD_FS;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd        = tlsf_pkg::CMD_PICK;
        state_next = S_DET_RD;
      end
      S_DET_RD: begin
        cmd        = tlsf_pkg::CMD_DET_RD;
        state_next = S_DET_LOAD;
      end
      S_DET_LOAD: begin
        cmd        = tlsf_pkg::CMD_DET_LOAD;
        state_next = S_DET_CLZ;
      end
      S_DET_CLZ: begin
        cmd        = tlsf_pkg::CMD_CLZ;
        state_next = S_DET_SHIFT;
      end
      S_DET_SHIFT: begin
        cmd        = tlsf_pkg::CMD_SHIFT;
        state_next = S_DET_A;
      end
      S_DET_A: begin
        cmd        = tlsf_pkg::CMD_DET_A;
        state_next = S_DET_B;
      end
      S_DET_B: begin
        cmd        = tlsf_pkg::CMD_DET_B;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd        = tlsf_pkg::CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= cfg_fire ? S_CLEAR : state_next;
      if (cmd == tlsf_pkg::CMD_EMIT) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/tlsf_free_block_index.sv
// Two-level segregated-fit free block index. An allocate's walk of a bucket list reads
// one list node per cycle from the size and link memories; requests run one at a time.
// Reset (synchronous, active high) and each configuration write empty the index and
// start a pass that clears all 1024 entries of the membership memory; no request is
// taken during it.
module tlsf_free_block_index (
  input logic         clk,
  input logic         rst,
  tlsf_req_if.sink    req,
  tlsf_rsp_if.source  rsp,
  tlsf_cfg_if.sink    cfg
);

  // The class width register is always writable; a write restarts the clearing pass.
  logic cfg_fire;

  // Command and status between the sequencer and the datapath.
  tlsf_pkg::cmd_t     cmd;
  tlsf_pkg::dp_stat_t stat;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;

  // The controller owns the handshakes: a request is taken only in its idle state,
  // and a finished response sits in the output register until the sink takes it,
  // while the next request may already be in progress.
  tlsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_fire  (cfg_fire),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the bitmaps, the bucket heads, the block sizes and both link
  // memories, and drives the response payload registers.
  tlsf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_fire      (cfg_fire),
    .cfg_data      (cfg.second_level_bits),
    .op_in         (req.op),
    .handle_in     (req.block_handle),
    .size_in       (req.size),
    .stat          (stat),
    .status        (rsp.status),
    .result_handle (rsp.result_handle),
    .result_size   (rsp.result_size)
  );

endmodule

### test/tlsf_tb_if.sv
// Testbench view of the free block index channels.
// The request, response and configuration interfaces come from the RTL files; this file
// holds only the result type and scoreboard used by the top level. Depends on tlsf_pkg.
package tlsf_tb_pkg;

  typedef struct packed {
    logic [1:0]                    status;
    logic [tlsf_pkg::HANDLE_W-1:0] handle;
    logic [tlsf_pkg::SIZE_W-1:0]   size;
  } alloc_result_t;

  class alloc_scoreboard;
    alloc_result_t pending[$];
    int            errors;
    int            matched;

    function void note_request(alloc_result_t r);
      pending.push_back(r);
    endfunction

    function void check_response(alloc_result_t got);
      alloc_result_t want;
      if (pending.size() == 0) begin
        $error("response with nothing outstanding: status %0d", got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      matched++;
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.handle !== want.handle) begin
        $error("result_handle expected %0d actual %0d", want.handle, got.handle);
        errors++;
      end
      if (got.size !== want.size) begin
        $error("result_size expected %0h actual %0h", want.size, got.size);
        errors++;
      end
    endfunction
  endclass
endpackage

### test/testbench.sv
// Self-checking testbench of tlsf_free_block_index.
// Drives insert, allocate and unlink requests under random idling, predicts every
// response with a behavioral copy of the index, and compares in a scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUCKETS_PER_FL = 32;
  localparam int HW = tlsf_pkg::HANDLE_W;
  localparam int LW = tlsf_pkg::LINK_W;
  localparam int NH = tlsf_pkg::NUM_HANDLES;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tlsf_req_if req();
  tlsf_rsp_if rsp();
  tlsf_cfg_if cfg();

  tlsf_free_block_index uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always #6 clk = ~clk;

  // Behavioral copy of the index. The bitmaps and membership flags guard every read of
  // the head and size arrays, so those never need a defined reset value.
  logic [2:0]                  sl_reg;
  logic [31:0]                 fl_map;
  logic [31:0]                 sl_maps[32];
  logic [LW-1:0]               heads[tlsf_pkg::NUM_BUCKETS];
  logic [tlsf_pkg::SIZE_W-1:0] sizes[NH];
  logic [LW-1:0]               nexts[NH];
  logic [LW-1:0]               prevs[NH];
  bit                          member[NH];

  tlsf_tb_pkg::alloc_scoreboard sb;
  int sender_idle_pct, receiver_stall_pct;
  int n_requests, n_allocs_hit;
  logic [HW-1:0] live[$];   // handles believed to be in the index

  function automatic int width_sl();
    return (sl_reg >= tlsf_pkg::SL_WIDE_MIN) ? 5 : 4;
  endfunction

  // Splits a size into its first and second class numbers.
  function automatic void size_class(input logic [31:0] sz, output int fl, output int sc);
    int m, sl;
    m = 0;
    for (int i = 0; i < 32; i++) if (sz[i]) m = i;
    sl = width_sl();
    if (m >= sl) sc = int'((sz >> (m - sl)) & ((1 << sl) - 1));
    else sc = int'((sz << (sl - m)) & ((1 << sl) - 1));
    fl = m;
  endfunction

  function automatic int lowest_set(input logic [31:0] v);
    for (int i = 0; i < 32; i++) if (v[i]) return i;
    return 31;
  endfunction

  function automatic void empty_index();
    fl_map = '0;
    for (int i = 0; i < 32; i++) sl_maps[i] = '0;
    for (int i = 0; i < NH; i++) begin
      member[i] = 0;
      nexts[i] = tlsf_pkg::LINK_NONE;
      prevs[i] = tlsf_pkg::LINK_NONE;
    end
  endfunction

  function automatic void take_out(input int h);
    int fl, sc, b;
    logic [LW-1:0] p, n;
    p = prevs[h];
    n = nexts[h];
    size_class(sizes[h], fl, sc);
    b = fl * BUCKETS_PER_FL + sc;
    if (p >= NH) begin
      heads[b] = (n < NH) ? n : '0;
      if (n >= NH) sl_maps[fl][sc] = 1'b0;
    end else begin
      nexts[p] = n;
    end
    if (n < NH) prevs[n] = p;
    if (sl_maps[fl] == 0) fl_map[fl] = 1'b0;
    nexts[h] = tlsf_pkg::LINK_NONE;
    prevs[h] = tlsf_pkg::LINK_NONE;
    member[h] = 0;
  endfunction

  // Applies one request to the model and returns the response it should produce.
  function automatic tlsf_tb_pkg::alloc_result_t predict_response(input logic [1:0] op,
      input logic [HW-1:0] h, input logic [31:0] sz);
    tlsf_tb_pkg::alloc_result_t r;
    int fl, sc, b, f, s, pick, cur, steps;
    logic [31:0] sm, fm;
    r = '{status: tlsf_pkg::ST_BAD, handle: '0, size: '0};
    if (op == tlsf_pkg::OP_INSERT) begin
      if (sz != 0 && !member[h]) begin
        size_class(sz, fl, sc);
        b = fl * BUCKETS_PER_FL + sc;
        sizes[h] = sz;
        prevs[h] = tlsf_pkg::LINK_NONE;
        if (sl_maps[fl][sc]) begin
          nexts[h] = heads[b];
          if (heads[b] < NH) prevs[heads[b]] = LW'(h);
        end else begin
          nexts[h] = tlsf_pkg::LINK_NONE;
        end
        heads[b] = LW'(h);
        member[h] = 1;
        sl_maps[fl][sc] = 1'b1;
        fl_map[fl] = 1'b1;
        r.status = tlsf_pkg::ST_DONE;
      end
    end else if (op == tlsf_pkg::OP_ALLOC) begin
      if (sz != 0) begin
        pick = NH;
        size_class(sz, fl, sc);
        b = fl * BUCKETS_PER_FL + sc;
        if (sl_maps[fl][sc]) begin
          cur = int'(heads[b]);
          steps = 0;
          while (cur < NH && steps < NH) begin
            if (sizes[cur] >= sz) begin
              pick = cur;
              break;
            end
            cur = int'(nexts[cur]);
            steps++;
          end
        end
        if (pick == NH) begin
          sm = 32'(sl_maps[fl] & ~((64'd2 << sc) - 1));
          if (sm != 0) begin
            pick = int'(heads[fl * BUCKETS_PER_FL + lowest_set(sm)]);
          end else begin
            fm = 32'(fl_map & ~((64'd2 << fl) - 1));
            if (fm != 0) begin
              f = lowest_set(fm);
              if (sl_maps[f] != 0) begin
                s = lowest_set(sl_maps[f]);
                pick = int'(heads[f * BUCKETS_PER_FL + s]);
              end
            end
          end
        end
        if (pick < NH && member[pick]) begin
          take_out(pick);
          r = '{status: tlsf_pkg::ST_DONE, handle: pick[HW-1:0], size: sizes[pick]};
        end else begin
          r.status = tlsf_pkg::ST_NOFIT;
        end
      end
    end else if (op == tlsf_pkg::OP_UNLINK) begin
      if (member[h]) begin
        take_out(h);
        r.status = tlsf_pkg::ST_DONE;
      end
    end
    return r;
  endfunction

  // Sends one request, predicting its response at the accepting edge. Valid stays
  // high after acceptance so that requests can follow without a gap; it drops while
  // the sender idles and before any drain.
  task automatic send_request(input logic [1:0] op, input logic [HW-1:0] h,
      input logic [31:0] sz);
    tlsf_tb_pkg::alloc_result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.block_handle <= h;
    req.size <= sz;
    do @(posedge clk); while (!req.ready);
    r = predict_response(op, h, sz);
    sb.note_request(r);
    n_requests++;
    if (op == tlsf_pkg::OP_INSERT && r.status == tlsf_pkg::ST_DONE) live.push_back(h);
    if (r.status == tlsf_pkg::ST_DONE && op != tlsf_pkg::OP_INSERT) begin
      foreach (live[i]) if (live[i] == (op == tlsf_pkg::OP_ALLOC ? r.handle : h)) begin
        live.delete(i);
        break;
      end
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Writing the register empties the index; done only when the block is idle.
  task automatic write_width(input logic [2:0] v);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.second_level_bits <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sl_reg = v;
    empty_index();
    live.delete();
  endtask

  // Size near a random power of two, mostly small so buckets collide.
  function automatic logic [31:0] rand_size();
    int m;
    logic [31:0] v;
    m = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(12);
    v = (32'd1 << m) | ($urandom & ((32'd1 << m) - 1));
    return v;
  endfunction

  task automatic random_requests(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        send_request(tlsf_pkg::OP_INSERT, HW'($urandom_range(80)), rand_size());
      else if (pick < 75) send_request(tlsf_pkg::OP_ALLOC, '0, rand_size());
      else if (pick < 88 && live.size() != 0)
        send_request(tlsf_pkg::OP_UNLINK, live[$urandom_range(live.size() - 1)], $urandom);
      else if (pick < 94) send_request(tlsf_pkg::OP_UNLINK, HW'($urandom), $urandom);
      else if (pick < 97) send_request(2'd3, HW'($urandom), $urandom);
      else send_request(2'($urandom_range(1)), HW'($urandom),
                        $urandom_range(1) ? 32'd0 : $urandom);
    end
  endtask

  // Response side: random stalls, check at every accepting edge.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      sb.check_response('{status: rsp.status, handle: rsp.result_handle,
                          size: rsp.result_size});
      if (rsp.status == tlsf_pkg::ST_DONE && rsp.result_size != 0) n_allocs_hit++;
    end
    rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sb = new();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    req.valid = 1'b0;
    req.op = tlsf_pkg::OP_INSERT;
    req.block_handle = '0;
    req.size = '0;
    cfg.valid = 1'b0;
    cfg.second_level_bits = 3'd4;
    rsp.ready = 1'b1;
    sl_reg = 3'd4;
    empty_index();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: size extremes, zero sizes, bad ops, duplicates and unlinks.
    send_request(tlsf_pkg::OP_INSERT, 10'd0, 32'hFFFF_FFFF);
    send_request(tlsf_pkg::OP_INSERT, 10'd1023, 32'd1);
    send_request(tlsf_pkg::OP_INSERT, 10'd1, 32'd0);
    send_request(tlsf_pkg::OP_ALLOC, 10'd0, 32'd0);
    send_request(tlsf_pkg::OP_INSERT, 10'd0, 32'd5);
    send_request(tlsf_pkg::OP_INSERT, 10'd2, 32'd20);
    send_request(tlsf_pkg::OP_INSERT, 10'd3, 32'd21);
    send_request(tlsf_pkg::OP_INSERT, 10'd4, 32'd22);
    send_request(tlsf_pkg::OP_UNLINK, 10'd3, 32'd0);
    send_request(tlsf_pkg::OP_UNLINK, 10'd3, 32'd0);
    send_request(2'd3, 10'h2AA, 32'h5555_5555);
    send_request(tlsf_pkg::OP_ALLOC, 10'd0, 32'd23);
    send_request(tlsf_pkg::OP_ALLOC, 10'd0, 32'd2);
    send_request(tlsf_pkg::OP_ALLOC, 10'd0, 32'd1);
    send_request(tlsf_pkg::OP_ALLOC, 10'd0, 32'hFFFF_FFFF);
    send_request(tlsf_pkg::OP_ALLOC, 10'd0, 32'hFFFF_FFFF);
    send_request(tlsf_pkg::OP_UNLINK, 10'd4, 32'd0);
    send_request(tlsf_pkg::OP_ALLOC, 10'd0, 32'd1);

    // The sender holds off until the block has answered everything.
    write_width(3'd5);
    send_request(tlsf_pkg::OP_INSERT, 10'd7, 32'd3);
    send_request(tlsf_pkg::OP_INSERT, 10'd8, 32'h8000_0000);
    send_request(tlsf_pkg::OP_ALLOC, 10'd0, 32'd4);

    random_requests(250);
    write_width(3'd0);
    sender_idle_pct = 49;
    random_requests(300);
    write_width(3'd7);
    sender_idle_pct = 0;
    receiver_stall_pct = 49;
    random_requests(300);
    write_width(3'd4);
    sender_idle_pct = 6;
    receiver_stall_pct = 6;
    random_requests(350);
    write_width(3'd5);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    random_requests(330);

    wait_drained();
    $display("Ran %0d requests over six class width settings; %0d allocations returned a block.",
             n_requests, n_allocs_hit);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tlsf_pkg.sv
hw/rtl/tlsf_req_if.sv
hw/rtl/tlsf_rsp_if.sv
hw/rtl/tlsf_cfg_if.sv
hw/rtl/tlsf_dp.sv
hw/rtl/tlsf_ctrl.sv
hw/rtl/tlsf_free_block_index.sv
test/tlsf_tb_if.sv
test/testbench.sv
